// File: hw/rtl/fcc_pkg.sv
`default_nettype none
package fcc_pkg;

  localparam int CLUSTER_COUNT = 1024;
  localparam int IDX_W         = $clog2(CLUSTER_COUNT);
  localparam int CNT_W         = IDX_W + 1;
  localparam int LINK_W        = IDX_W + 1;

  localparam logic [LINK_W-1:0] LINK_FREE = '0;
  localparam logic [LINK_W-1:0] LINK_END  = {1'b1, {IDX_W{1'b0}}};
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CLUSTER_COUNT - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CLUSTER_COUNT);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_END,
    S_FREE_RD,
    S_FREE_CHK,
    S_READ_RD,
    S_READ_CHK
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/fat_cluster_chain_manager_unit.sv
`default_nettype none
// FAT cluster chain manager with a 1024-entry link table.
// Input channel: a word (in_op, in_cluster_count, in_cluster_index) is taken
// at a rising edge where start is high and busy is low.
// Result channel: every accepted word yields one result word, shown for one
// cycle with out_valid high. The receiver cannot stall, so results are never
// held back and the block does not wait on the receiver.
// Steps: an empty allocate or an unused op is answered in the cycle after it
// is taken. A read passes S_READ_RD and S_READ_CHK before its result is
// registered. Allocate scans the table once from entry 0 upward, through
// S_ALLOC_RD and S_ALLOC_CHK per entry visited, then S_ALLOC_END. Free walks
// the chain through S_FREE_RD and S_FREE_CHK per link, at most 1024 links; the table read is registered.
// Reset: after rst_n is released the table is cleared one entry per cycle,
// with busy high; no word is taken until the clear is done.
module fat_cluster_chain_manager_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_op,
  input  wire logic [fcc_pkg::CNT_W-1:0] in_cluster_count,
  input  wire logic [fcc_pkg::IDX_W-1:0] in_cluster_index,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [fcc_pkg::IDX_W-1:0]     out_cluster_out,
  output logic                          out_end_of_chain,
  output logic [fcc_pkg::CNT_W-1:0]     out_clusters_done
);

  fcc_pkg::state_t state_r, state_nxt;
  logic [fcc_pkg::IDX_W-1:0] ptr_r, ptr_nxt;
  logic [fcc_pkg::IDX_W-1:0] prev_r, prev_nxt;
  logic [fcc_pkg::IDX_W-1:0] head_r, head_nxt;
  logic                      have_prev_r, have_prev_nxt;
  logic [fcc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [fcc_pkg::CNT_W-1:0] done_r, done_nxt;
  logic [1:0]                op_r, op_nxt;
  fcc_pkg::status_t          st_r, st_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [fcc_pkg::IDX_W-1:0] out_cl_r, out_cl_nxt;
  logic                      out_eoc_r, out_eoc_nxt;
  logic [fcc_pkg::CNT_W-1:0] out_done_r, out_done_nxt;

  logic                       ram_we;
  logic [fcc_pkg::IDX_W-1:0]  ram_waddr;
  logic [fcc_pkg::LINK_W-1:0] ram_wdata;
  logic [fcc_pkg::IDX_W-1:0]  ram_raddr;
  logic [fcc_pkg::LINK_W-1:0] ram_rdata;
  logic [fcc_pkg::CNT_W-1:0]  done_inc;

  fcc_ram #(
    .ADDR_W(fcc_pkg::IDX_W),
    .DATA_W(fcc_pkg::LINK_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign done_inc = done_r + fcc_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcc_pkg::S_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    head_r       <= head_nxt;
    have_prev_r  <= have_prev_nxt;
    count_r      <= count_nxt;
    done_r       <= done_nxt;
    op_r         <= op_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_cl_r     <= out_cl_nxt;
    out_eoc_r    <= out_eoc_nxt;
    out_done_r   <= out_done_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    prev_nxt       = prev_r;
    head_nxt       = head_r;
    have_prev_nxt  = have_prev_r;
    count_nxt      = count_r;
    done_nxt       = done_r;
    op_nxt         = op_r;
    st_nxt         = st_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_cl_nxt     = out_cl_r;
    out_eoc_nxt    = out_eoc_r;
    out_done_nxt   = out_done_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r;
    ram_wdata      = fcc_pkg::LINK_FREE;
    ram_raddr      = ptr_r;

    unique case (state_r)
      fcc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = fcc_pkg::LINK_FREE;
        ptr_nxt   = ptr_r + fcc_pkg::IDX_W'(1);
        if (ptr_r == fcc_pkg::LAST_IDX) begin
          state_nxt = fcc_pkg::S_IDLE;
        end
      end
      fcc_pkg::S_IDLE: begin
        if (start) begin
          op_nxt        = in_op;
          count_nxt     = in_cluster_count;
          done_nxt      = '0;
          head_nxt      = '0;
          have_prev_nxt = 1'b0;
          st_nxt        = fcc_pkg::ST_OK;
          unique case (in_op)
            fcc_pkg::OP_ALLOC: begin
              if (in_cluster_count == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fcc_pkg::ST_EMPTY;
                out_cl_nxt     = '0;
                out_eoc_nxt    = 1'b0;
                out_done_nxt   = '0;
              end else begin
                ptr_nxt   = '0;
                state_nxt = fcc_pkg::S_ALLOC_RD;
              end
            end
            fcc_pkg::OP_FREE: begin
              ptr_nxt   = in_cluster_index;
              state_nxt = fcc_pkg::S_FREE_RD;
            end
            fcc_pkg::OP_READ: begin
              ptr_nxt   = in_cluster_index;
              state_nxt = fcc_pkg::S_READ_RD;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = fcc_pkg::ST_BAD;
              out_cl_nxt     = '0;
              out_eoc_nxt    = 1'b0;
              out_done_nxt   = '0;
            end
          endcase
        end
      end
      fcc_pkg::S_ALLOC_RD: begin
        ram_raddr = ptr_r;
        state_nxt = fcc_pkg::S_ALLOC_CHK;
      end
      fcc_pkg::S_ALLOC_CHK: begin
        if (ram_rdata == fcc_pkg::LINK_FREE) begin
          // The previous cluster is linked to this one; the end marker is written in S_ALLOC_END.
          if (have_prev_r) begin
            ram_we    = 1'b1;
            ram_waddr = prev_r;
            ram_wdata = {1'b0, ptr_r};
          end else begin
            head_nxt = ptr_r;
          end
          prev_nxt      = ptr_r;
          have_prev_nxt = 1'b1;
          done_nxt      = done_inc;
          if (done_inc == count_r) begin
            state_nxt = fcc_pkg::S_ALLOC_END;
          end else if (ptr_r == fcc_pkg::LAST_IDX) begin
            st_nxt    = fcc_pkg::ST_NO_SPACE;
            state_nxt = fcc_pkg::S_ALLOC_END;
          end else begin
            ptr_nxt   = ptr_r + fcc_pkg::IDX_W'(1);
            state_nxt = fcc_pkg::S_ALLOC_RD;
          end
        end else if (ptr_r == fcc_pkg::LAST_IDX) begin
          st_nxt    = fcc_pkg::ST_NO_SPACE;
          state_nxt = fcc_pkg::S_ALLOC_END;
        end else begin
          ptr_nxt   = ptr_r + fcc_pkg::IDX_W'(1);
          state_nxt = fcc_pkg::S_ALLOC_RD;
        end
      end
      fcc_pkg::S_ALLOC_END: begin
        if (have_prev_r) begin
          ram_we    = 1'b1;
          ram_waddr = prev_r;
          ram_wdata = fcc_pkg::LINK_END;
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = st_r;
        out_cl_nxt     = head_r;
        out_eoc_nxt    = 1'b0;
        out_done_nxt   = done_r;
        state_nxt      = fcc_pkg::S_IDLE;
      end
      fcc_pkg::S_FREE_RD: begin
        ram_raddr = ptr_r;
        state_nxt = fcc_pkg::S_FREE_CHK;
      end
      fcc_pkg::S_FREE_CHK: begin
        out_cl_nxt  = '0;
        out_eoc_nxt = 1'b0;
        if (ram_rdata == fcc_pkg::LINK_FREE) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fcc_pkg::ST_BAD;
          out_done_nxt   = done_r;
          state_nxt      = fcc_pkg::S_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr_r;
          ram_wdata = fcc_pkg::LINK_FREE;
          done_nxt  = done_inc;
          ptr_nxt   = ram_rdata[fcc_pkg::IDX_W-1:0];
          if (ram_rdata == fcc_pkg::LINK_END) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fcc_pkg::ST_OK;
            out_done_nxt   = done_inc;
            state_nxt      = fcc_pkg::S_IDLE;
          end else if (done_inc == fcc_pkg::FULL_CNT) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fcc_pkg::ST_BAD;
            out_done_nxt   = done_inc;
            state_nxt      = fcc_pkg::S_IDLE;
          end else begin
            state_nxt = fcc_pkg::S_FREE_RD;
          end
        end
      end
      fcc_pkg::S_READ_RD: begin
        ram_raddr = ptr_r;
        state_nxt = fcc_pkg::S_READ_CHK;
      end
      fcc_pkg::S_READ_CHK: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fcc_pkg::ST_OK;
        out_done_nxt   = '0;
        if (ram_rdata == fcc_pkg::LINK_END) begin
          out_eoc_nxt = 1'b1;
          out_cl_nxt  = '0;
        end else begin
          out_eoc_nxt = 1'b0;
          out_cl_nxt  = ram_rdata[fcc_pkg::IDX_W-1:0];
        end
        state_nxt = fcc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fcc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != fcc_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_cluster_out   = out_cl_r;
  assign out_end_of_chain  = out_eoc_r;
  assign out_clusters_done = out_done_r;

`ifndef SYNTHESIS
  a_walk_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == fcc_pkg::OP_FREE || in_op == fcc_pkg::OP_READ))
      |=> busy)
    else $error("walk request did not hold the block busy");

  a_eoc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_chain) |->
      (out_status == fcc_pkg::ST_OK && out_cluster_out == '0 &&
       out_clusters_done == '0))
    else $error("end-of-chain result carries stray fields");

  a_alloc_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == fcc_pkg::OP_ALLOC && out_status == fcc_pkg::ST_OK)
      |-> (out_clusters_done == count_r))
    else $error("allocate reported ok with a short chain");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcc_pkg::S_CLEAR) |-> !out_valid)
    else $error("result strobe during table clear");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/fcc_ram.sv
`default_nettype none
module fcc_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
  import fcc_pkg::*;

  localparam int CLUSTERS = CLUSTER_COUNT;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [15:0] LINK_NONE = 16'h0000;
  localparam logic [15:0] LINK_LAST = 16'hFFFF;
  localparam int RANDOM_TARGET = 290;
  localparam int BATCH_WORDS = 6;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2100;

  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] index;
  } chain_word_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] cluster;
    logic             eoc;
    logic [CNT_W-1:0] done;
  } chain_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_op = '0;
  logic [CNT_W-1:0] in_cluster_count = '0;
  logic [IDX_W-1:0] in_cluster_index = '0;
  logic busy;
  logic out_valid;
  logic [1:0] out_status;
  logic [IDX_W-1:0] out_cluster_out;
  logic out_end_of_chain;
  logic [CNT_W-1:0] out_clusters_done;

  logic [15:0] fat_shadow [CLUSTERS];
  bit linked_to [CLUSTERS];
  int head_list [$];
  int used_list [$];

  chain_word_t word_queue [$];
  chain_result_t pending_results [$];
  chain_word_t next_word;
  chain_result_t want;
  bit took;
  int burst_left = 1;
  int gap_left = 0;
  int queued_words = 0;
  int accepted_words = 0;
  int errors = 0;
  int idle_cycles = 0;
  int op_tally [4];
  int status_tally [4];

  fat_cluster_chain_manager_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_cluster_count  (in_cluster_count),
    .in_cluster_index  (in_cluster_index),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_cluster_out   (out_cluster_out),
    .out_end_of_chain  (out_end_of_chain),
    .out_clusters_done (out_clusters_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic chain_result_t fat_predict(logic [1:0] op, logic [CNT_W-1:0] count,
                                                logic [IDX_W-1:0] index);
    chain_result_t r;
    int unsigned cur;
    int unsigned nxt;
    int unsigned taken;
    int unsigned prev;
    int unsigned probe;
    bit walking;
    bit have_prev;
    r.status = ST_OK;
    r.cluster = '0;
    r.eoc = 1'b0;
    r.done = '0;
    taken = 0;
    case (op)
      OP_ALLOC: begin
        if (count == '0) begin
          r.status = ST_EMPTY;
        end else begin
          probe = 0;
          prev = 0;
          have_prev = 1'b0;
          walking = 1'b1;
          while (walking && taken < count) begin
            while (probe < CLUSTERS && fat_shadow[probe] != LINK_NONE) probe++;
            if (probe >= CLUSTERS) begin
              r.status = ST_NO_SPACE;
              walking = 1'b0;
            end else begin
              fat_shadow[probe] = LINK_LAST;
              if (have_prev) fat_shadow[prev] = 16'(probe);
              else r.cluster = IDX_W'(probe);
              prev = probe;
              have_prev = 1'b1;
              taken++;
            end
          end
        end
      end
      OP_FREE: begin
        cur = index;
        walking = 1'b1;
        while (walking) begin
          if (cur == LINK_LAST) begin
            walking = 1'b0;
          end else if (cur >= CLUSTERS || taken >= CLUSTERS) begin
            r.status = ST_BAD;
            walking = 1'b0;
          end else begin
            nxt = fat_shadow[cur];
            if (nxt == LINK_NONE) begin
              r.status = ST_BAD;
              walking = 1'b0;
            end else begin
              fat_shadow[cur] = LINK_NONE;
              taken++;
              cur = nxt;
            end
          end
        end
      end
      OP_READ: begin
        if (fat_shadow[index] == LINK_LAST) r.eoc = 1'b1;
        else r.cluster = fat_shadow[index][IDX_W-1:0];
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    r.done = CNT_W'(taken);
    return r;
  endfunction

  task automatic queue_word(logic [1:0] op, int unsigned count, int unsigned index);
    chain_word_t w;
    w.op = op;
    w.count = CNT_W'(count);
    w.index = IDX_W'(index);
    word_queue.push_back(w);
    queued_words++;
  endtask

  task automatic survey_table();
    logic [15:0] link;
    head_list.delete();
    used_list.delete();
    for (int i = 0; i < CLUSTERS; i++) linked_to[i] = 1'b0;
    for (int i = 0; i < CLUSTERS; i++) begin
      link = fat_shadow[i];
      if (link != LINK_NONE && link != LINK_LAST && link < CLUSTERS) linked_to[link] = 1'b1;
    end
    for (int i = 0; i < CLUSTERS; i++) begin
      if (fat_shadow[i] != LINK_NONE) begin
        used_list.push_back(i);
        if (!linked_to[i]) head_list.push_back(i);
      end
    end
  endtask

  task automatic plan_batch();
    int pick;
    int mode;
    int alloc_share;
    int unsigned count;
    int unsigned index;
    survey_table();
    alloc_share = (used_list.size() > 768) ? 20 : 45;
    for (int b = 0; b < BATCH_WORDS; b++) begin
      pick = $urandom_range(0, 99);
      mode = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_word(OP_SPARE, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else if (pick < 5 + alloc_share) begin
        if (mode < 3) count = 0;
        else if (mode < 85) count = $urandom_range(1, 12);
        else if (mode < 96) count = $urandom_range(13, 200);
        else count = $urandom_range(900, 2047);
        queue_word(OP_ALLOC, count, $urandom_range(0, 1023));
      end else if (pick < 80) begin
        if (mode < 70 && head_list.size() > 0)
          index = head_list[$urandom_range(0, head_list.size() - 1)];
        else if (mode < 85 && used_list.size() > 0)
          index = used_list[$urandom_range(0, used_list.size() - 1)];
        else
          index = $urandom_range(0, 1023);
        queue_word(OP_FREE, $urandom_range(0, 2047), index);
      end else begin
        if (mode < 60 && used_list.size() > 0)
          index = used_list[$urandom_range(0, used_list.size() - 1)];
        else
          index = $urandom_range(0, 1023);
        queue_word(OP_READ, $urandom_range(0, 2047), index);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        pending_results.push_back(fat_predict(in_op, in_cluster_count, in_cluster_index));
        op_tally[in_op]++;
        accepted_words++;
      end
      if (took || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_queue.size() > 0) begin
          next_word = word_queue.pop_front();
          in_op <= next_word.op;
          in_cluster_count <= next_word.count;
          in_cluster_index <= next_word.index;
          start <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 24);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no word pending: status %0d cluster %0d eoc %0d done %0d",
                 $time, out_status, out_cluster_out, out_end_of_chain, out_clusters_done);
        errors++;
      end else begin
        want = pending_results.pop_front();
        status_tally[want.status]++;
        if (out_status !== want.status || out_cluster_out !== want.cluster ||
            out_end_of_chain !== want.eoc || out_clusters_done !== want.done) begin
          $display("%0t: mismatch expected status %0d cluster %0d eoc %0d done %0d, %s %0d %0d %0d %0d",
                   $time, want.status, want.cluster, want.eoc, want.done, "actual",
                   out_status, out_cluster_out, out_end_of_chain, out_clusters_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CLUSTERS; i++) fat_shadow[i] = LINK_NONE;
    for (int i = 0; i < 4; i++) begin
      op_tally[i] = 0;
      status_tally[i] = 0;
    end
    queue_word(OP_ALLOC, 0, 0);
    queue_word(OP_READ, 0, 0);
    queue_word(OP_FREE, 0, 0);
    queue_word(OP_ALLOC, 1, 0);
    queue_word(OP_READ, 0, 0);
    queue_word(OP_ALLOC, 3, 0);
    queue_word(OP_READ, 0, 1);
    queue_word(OP_FREE, 0, 2);
    queue_word(OP_FREE, 0, 1);
    queue_word(OP_ALLOC, 1024, 0);
    queue_word(OP_ALLOC, 5, 0);
    queue_word(OP_READ, 0, 1023);
    queue_word(OP_SPARE, 2047, 1023);
    queue_word(OP_FREE, 0, 0);
    queue_word(OP_FREE, 0, 1);
    queue_word(OP_ALLOC, 2047, 1023);
    queue_word(OP_READ, 0, 1023);
    queue_word(OP_READ, 0, 512);
    queue_word(OP_FREE, 0, 0);
    queue_word(OP_ALLOC, 1024, 0);
    queue_word(OP_FREE, 0, 512);
    queue_word(OP_FREE, 0, 0);
    queue_word(OP_READ, 0, 700);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (queued_words < RANDOM_TARGET) begin
      while (accepted_words != queued_words) @(negedge clk);
      plan_batch();
    end
    while (accepted_words != queued_words || pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Ran %0d words: %0d allocate, %0d free, %0d read, %0d unused op.",
             accepted_words, op_tally[OP_ALLOC], op_tally[OP_FREE], op_tally[OP_READ],
             op_tally[OP_SPARE]);
    $display("Statuses seen: %0d ok, %0d no space, %0d empty, %0d bad cluster.",
             status_tally[ST_OK], status_tally[ST_NO_SPACE], status_tally[ST_EMPTY],
             status_tally[ST_BAD]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
